// ===== rtl/core/tlr_pkg.sv =====
// Shared types and constants for the text line layout block.
// No dependencies; imported by every module of the block.
package tlr_pkg;

  // field widths of the streams and registers
  localparam int unsigned XIN_BITS   = 15;
  localparam int unsigned CODE_BITS  = 8;
  localparam int unsigned GLYPH_BITS = 8;
  localparam int unsigned TAB_BITS   = 10;
  localparam int unsigned LH_BITS    = 8;
  localparam int unsigned OUT_IDX_BITS = 16;
  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS  = 15;
  localparam int unsigned S_TDATA_BITS = 48;
  localparam int unsigned M_TDATA_BITS = 80;

  // remainder unit resolves this many quotient bits per cycle
  localparam int unsigned DIV_STEP_BITS = 4;

  // item commands
  localparam logic [1:0] CMD_BEGIN = 2'd0;
  localparam logic [1:0] CMD_CHAR  = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;

  // character codes
  localparam logic [7:0] CHR_TAB     = 8'd9;
  localparam logic [7:0] CHR_NEWLINE = 8'd10;
  localparam logic [7:0] CHR_PRINT_LO = 8'd32;
  localparam logic [7:0] CHR_PRINT_HI = 8'd127;

  // character classes
  localparam logic [1:0] CLS_OTHER   = 2'd0;
  localparam logic [1:0] CLS_NEWLINE = 2'd1;
  localparam logic [1:0] CLS_TAB     = 2'd2;
  localparam logic [1:0] CLS_PRINT   = 2'd3;

  // register indexes
  localparam logic [2:0] REG_FRAME_LEFT   = 3'd0;
  localparam logic [2:0] REG_FRAME_RIGHT  = 3'd1;
  localparam logic [2:0] REG_FRAME_BOTTOM = 3'd2;
  localparam logic [2:0] REG_TAB_WIDTH    = 3'd3;
  localparam logic [2:0] REG_LINE_HEIGHT  = 3'd4;

  // register reset values
  localparam logic [14:0] RST_FRAME_LEFT   = 15'd0;
  localparam logic [14:0] RST_FRAME_RIGHT  = 15'd1023;
  localparam logic [14:0] RST_FRAME_BOTTOM = 15'd767;
  localparam logic [9:0]  RST_TAB_WIDTH    = 10'd72;
  localparam logic [7:0]  RST_LINE_HEIGHT  = 8'd16;

  // datapath operations
  localparam logic [3:0] OP_NONE      = 4'd0;
  localparam logic [3:0] OP_BEGIN     = 4'd1;
  localparam logic [3:0] OP_END       = 4'd2;
  localparam logic [3:0] OP_NEWLINE   = 4'd3;
  localparam logic [3:0] OP_PRINT     = 4'd4;
  localparam logic [3:0] OP_OTHER     = 4'd5;
  localparam logic [3:0] OP_TAB_FLUSH = 4'd6;
  localparam logic [3:0] OP_TAB_STOP  = 4'd7;
  localparam logic [3:0] OP_TAB_RUN   = 4'd8;

  typedef struct packed {
    logic       ld_item;
    logic [3:0] op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] item_cmd;
    logic [1:0] char_class;
    logic       stopped;
    logic       out_free;
    logic       div_done;
    logic       tab_wrap;
    logic       nl_stop;
  } dp_status_t;

endpackage

// ===== rtl/core/tlr_rem.sv =====
// Multi-cycle remainder unit for tab stop spacing, DIV_STEP_BITS bits a cycle.
// Depends on tlr_pkg.
module tlr_rem #(
  parameter int MAG_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [MAG_BITS-1:0]          dividend,
  input  logic [tlr_pkg::TAB_BITS-1:0] divisor,
  output logic                         done,
  output logic [tlr_pkg::TAB_BITS-1:0] rem
);
  import tlr_pkg::*;

  localparam int NITER = (MAG_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
  localparam int PADW  = NITER * DIV_STEP_BITS;
  localparam int CNTW  = $clog2(NITER + 1);

  logic [PADW-1:0]     shreg;
  logic [PADW-1:0]     sh_next;
  logic [TAB_BITS-1:0] div_q;
  logic [TAB_BITS:0]   part;
  logic [TAB_BITS-1:0] rem_next;
  logic [CNTW-1:0]     cnt;
  logic                busy;

  always_comb begin
    part = {1'b0, rem};
    sh_next = shreg;
    for (int i = 0; i < DIV_STEP_BITS; i++) begin
      part = {part[TAB_BITS-1:0], sh_next[PADW-1]};
      if (part >= {1'b0, div_q}) begin
        part = part - {1'b0, div_q};
      end
      sh_next = {sh_next[PADW-2:0], 1'b0};
    end
    rem_next = part[TAB_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(NITER);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= PADW'(dividend);
      div_q <= divisor;
      rem   <= '0;
    end else if (busy) begin
      shreg <= sh_next;
      rem   <= rem_next;
    end
  end

endmodule

// ===== rtl/core/tlr_datapath.sv =====
// Layout state, config registers, tab stop arithmetic and the result register.
// Depends on tlr_pkg and tlr_rem.
module tlr_datapath #(
  parameter int COORD_BITS = 16,
  parameter int INDEX_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [tlr_pkg::S_TDATA_BITS-1:0]   s_tdata,
  input  logic [1:0]                         s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [tlr_pkg::M_TDATA_BITS-1:0]   m_tdata,
  output logic [0:0]                         m_tuser,
  output logic                               m_tlast,
  input  logic                               cfg_valid,
  input  logic [tlr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [tlr_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  tlr_pkg::ctrl_cmd_t                 cmd,
  output tlr_pkg::dp_status_t                status
);
  import tlr_pkg::*;

  localparam int XW = (COORD_BITS > 15) ? COORD_BITS : 15;
  localparam int IW = INDEX_BITS;
  localparam logic [XW-1:0] CMASK = XW'((64'd1 << COORD_BITS) - 64'd1);

  // config
  logic [14:0]         frame_left, frame_right, frame_bottom;
  logic [TAB_BITS-1:0] tab_width;
  logic [LH_BITS-1:0]  line_height;

  // latched item
  logic [1:0]            item_cmd;
  logic [XIN_BITS-1:0]   item_sx, item_sy;
  logic [CODE_BITS-1:0]  item_code;
  logic [GLYPH_BITS-1:0] item_width;

  // layout state
  logic [XW-1:0] pen_x, run_x, line_y, stop_x;
  logic [XW-1:0] pen_x_next, run_x_next, line_y_next, stop_x_next;
  logic [IW-1:0] run_count, run_first, char_counter;
  logic [IW-1:0] run_count_next, run_first_next, char_counter_next;
  logic          stopped, stopped_next;
  logic          neg_q;

  // result register payload
  logic [14:0] o_sx, o_y, o_ex;
  logic [15:0] o_first, o_len;
  logic        o_done, o_last;

  // emit request
  logic          emit;
  logic [XW-1:0] e_sx, e_ex;
  logic [IW-1:0] e_first, e_len;
  logic          e_done, e_last;

  // arithmetic
  logic [XW-1:0]       left_x, right_x, bottom_x;
  logic [XW:0]         p_sum, lw_sum, ny_sum, off, off_n, tab2_sum;
  logic [XW-1:0]       p_x, lw_x, ny, mag, tab2_x, stop_calc;
  logic [XW+1:0]       st_sum;
  logic [TAB_BITS-1:0] tw_eff, rem;
  logic                nl_stop, tab_wrap, off_neg, div_done, out_free;
  logic [1:0]          char_class;
  logic [IW-1:0]       cc_inc, rc_inc;

  assign left_x   = XW'(frame_left);
  assign right_x  = XW'(frame_right);
  assign bottom_x = XW'(frame_bottom);
  assign tw_eff   = (tab_width == '0) ? TAB_BITS'(1) : tab_width;

  assign p_sum  = {1'b0, pen_x} + (XW+1)'(item_width);
  assign p_x    = p_sum[XW-1:0] & CMASK;
  assign lw_sum = {1'b0, left_x} + (XW+1)'(item_width);
  assign lw_x   = lw_sum[XW-1:0] & CMASK;
  assign ny_sum = {1'b0, line_y} + (XW+1)'(line_height);
  assign ny     = ny_sum[XW-1:0] & CMASK;
  assign nl_stop = (ny >= bottom_x);

  // offset from the left edge; sign kept apart for truncating remainder
  assign off     = {1'b0, pen_x} - {1'b0, left_x};
  assign off_n   = -off;
  assign off_neg = off[XW];
  assign mag     = off_neg ? off_n[XW-1:0] : off[XW-1:0];

  // behind the left edge the stop lands at pen + rem + tab
  assign st_sum = neg_q ? ({2'b0, pen_x} + (XW+2)'(rem) + (XW+2)'(tw_eff))
                        : ({2'b0, pen_x} - (XW+2)'(rem) + (XW+2)'(tw_eff));
  assign stop_calc = st_sum[XW-1:0] & CMASK;
  assign tab_wrap  = (stop_calc > right_x);
  assign tab2_sum  = {1'b0, left_x} + (XW+1)'(tw_eff);
  assign tab2_x    = tab2_sum[XW-1:0] & CMASK;

  assign cc_inc = char_counter + 1'b1;
  assign rc_inc = run_count + 1'b1;

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    if (item_code == CHR_NEWLINE) begin
      char_class = CLS_NEWLINE;
    end else if (item_code == CHR_TAB) begin
      char_class = CLS_TAB;
    end else if (item_code >= CHR_PRINT_LO && item_code <= CHR_PRINT_HI) begin
      char_class = CLS_PRINT;
    end else begin
      char_class = CLS_OTHER;
    end
  end

  tlr_rem #(.MAG_BITS(XW)) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.op == OP_TAB_FLUSH),
    .dividend (mag),
    .divisor  (tw_eff),
    .done     (div_done),
    .rem      (rem)
  );

  always_comb begin
    pen_x_next        = pen_x;
    run_x_next        = run_x;
    line_y_next       = line_y;
    stop_x_next       = stop_x;
    run_count_next    = run_count;
    run_first_next    = run_first;
    char_counter_next = char_counter;
    stopped_next      = stopped;
    emit    = 1'b0;
    e_sx    = run_x;
    e_ex    = pen_x;
    e_first = run_first;
    e_len   = run_count;
    e_done  = 1'b0;
    e_last  = 1'b0;
    unique case (cmd.op)
      OP_NONE: begin
      end
      OP_BEGIN: begin
        pen_x_next        = XW'(item_sx) & CMASK;
        run_x_next        = XW'(item_sx) & CMASK;
        line_y_next       = XW'(item_sy) & CMASK;
        run_count_next    = '0;
        run_first_next    = '0;
        char_counter_next = '0;
        stopped_next      = 1'b0;
      end
      OP_END: begin
        if (!stopped && line_y < bottom_x) begin
          emit   = 1'b1;
          e_done = 1'b1;
          e_last = 1'b1;
        end
        stopped_next = 1'b1;
      end
      OP_NEWLINE: begin
        emit   = 1'b1;
        e_ex   = right_x;
        e_len  = rc_inc;
        e_last = 1'b1;
        char_counter_next = cc_inc;
        run_count_next    = '0;
        run_x_next        = left_x;
        line_y_next       = ny;
        stopped_next      = nl_stop;
        pen_x_next        = left_x;
        run_first_next    = cc_inc;
      end
      OP_PRINT: begin
        if (p_x > right_x) begin
          emit   = 1'b1;
          e_ex   = right_x;
          e_last = 1'b1;
          run_x_next   = left_x;
          line_y_next  = ny;
          stopped_next = nl_stop;
          run_first_next = char_counter;
          if (nl_stop) begin
            pen_x_next     = left_x;
            run_count_next = '0;
          end else begin
            // glyph placed on the new line without a second wrap
            pen_x_next        = lw_x;
            run_count_next    = IW'(1);
            char_counter_next = cc_inc;
          end
        end else begin
          pen_x_next        = p_x;
          char_counter_next = cc_inc;
          run_count_next    = rc_inc;
        end
      end
      OP_OTHER: begin
        char_counter_next = cc_inc;
        run_count_next    = rc_inc;
      end
      OP_TAB_FLUSH: begin
        if (run_count != '0) begin
          emit = 1'b1;
          run_x_next     = pen_x;
          run_count_next = '0;
          run_first_next = char_counter;
        end
      end
      OP_TAB_STOP: begin
        if (tab_wrap) begin
          emit   = 1'b1;
          e_ex   = right_x;
          e_last = nl_stop;
          run_count_next = '0;
          run_x_next     = left_x;
          line_y_next    = ny;
          stopped_next   = nl_stop;
          pen_x_next     = left_x;
          run_first_next = char_counter;
          stop_x_next    = tab2_x;
        end else begin
          stop_x_next = stop_calc;
        end
      end
      OP_TAB_RUN: begin
        emit    = 1'b1;
        e_ex    = stop_x;
        e_first = char_counter;
        e_len   = IW'(1);
        e_last  = 1'b1;
        pen_x_next        = stop_x;
        run_x_next        = stop_x;
        char_counter_next = cc_inc;
        run_count_next    = '0;
        run_first_next    = cc_inc;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_left   <= RST_FRAME_LEFT;
      frame_right  <= RST_FRAME_RIGHT;
      frame_bottom <= RST_FRAME_BOTTOM;
      tab_width    <= RST_TAB_WIDTH;
      line_height  <= RST_LINE_HEIGHT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_LEFT:   frame_left   <= cfg_data;
        REG_FRAME_RIGHT:  frame_right  <= cfg_data;
        REG_FRAME_BOTTOM: frame_bottom <= cfg_data;
        REG_TAB_WIDTH:    tab_width    <= cfg_data[TAB_BITS-1:0];
        REG_LINE_HEIGHT:  line_height  <= cfg_data[LH_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x        <= '0;
      run_x        <= '0;
      line_y       <= '0;
      run_count    <= '0;
      run_first    <= '0;
      char_counter <= '0;
      stopped      <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      pen_x        <= pen_x_next;
      run_x        <= run_x_next;
      line_y       <= line_y_next;
      run_count    <= run_count_next;
      run_first    <= run_first_next;
      char_counter <= char_counter_next;
      stopped      <= stopped_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    stop_x <= stop_x_next;
    if (cmd.op == OP_TAB_FLUSH) begin
      neg_q <= off_neg;
    end
    if (cmd.ld_item) begin
      item_cmd   <= s_tuser;
      item_sx    <= s_tdata[14:0];
      item_sy    <= s_tdata[29:15];
      item_code  <= s_tdata[37:30];
      item_width <= s_tdata[45:38];
    end
    if (emit) begin
      o_sx    <= e_sx[14:0];
      o_y     <= line_y[14:0];
      o_ex    <= e_ex[14:0];
      o_first <= OUT_IDX_BITS'(e_first);
      o_len   <= OUT_IDX_BITS'(e_len);
      o_done  <= e_done;
      o_last  <= e_last;
    end
  end

  assign m_tdata = {3'b000, o_len, o_first, o_ex, o_y, o_sx};
  assign m_tuser = o_done;
  assign m_tlast = o_last;

  assign status.item_cmd   = item_cmd;
  assign status.char_class = char_class;
  assign status.stopped    = stopped;
  assign status.out_free   = out_free;
  assign status.div_done   = div_done;
  assign status.tab_wrap   = tab_wrap;
  assign status.nl_stop    = nl_stop;

endmodule

// ===== rtl/core/tlr_ctrl.sv =====
// Sequencer for the layout block: takes a word, steps the datapath operations.
// Depends on tlr_pkg.
module tlr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output tlr_pkg::ctrl_cmd_t  cmd,
  input  tlr_pkg::dp_status_t status
);
  import tlr_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_TSTOP = 3'd3;
  localparam logic [2:0] S_TRUN  = 3'd4;

  logic [2:0] state, state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    cmd.ld_item = 1'b0;
    cmd.op      = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.ld_item = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (status.item_cmd)
          CMD_BEGIN: begin
            cmd.op     = OP_BEGIN;
            state_next = S_IDLE;
          end
          CMD_END: begin
            if (status.out_free) begin
              cmd.op     = OP_END;
              state_next = S_IDLE;
            end
          end
          CMD_CHAR: begin
            if (status.stopped) begin
              state_next = S_IDLE;
            end else if (status.out_free) begin
              unique case (status.char_class)
                CLS_NEWLINE: begin
                  cmd.op     = OP_NEWLINE;
                  state_next = S_IDLE;
                end
                CLS_PRINT: begin
                  cmd.op     = OP_PRINT;
                  state_next = S_IDLE;
                end
                CLS_TAB: begin
                  cmd.op     = OP_TAB_FLUSH;
                  state_next = S_DIV;
                end
                default: begin
                  cmd.op     = OP_OTHER;
                  state_next = S_IDLE;
                end
              endcase
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_DIV: begin
        if (status.div_done) begin
          state_next = S_TSTOP;
        end
      end
      S_TSTOP: begin
        if (status.out_free) begin
          cmd.op = OP_TAB_STOP;
          // wrapping below the bottom ends the tab there
          state_next = (status.tab_wrap && status.nl_stop) ? S_IDLE : S_TRUN;
        end
      end
      S_TRUN: begin
        if (status.out_free) begin
          cmd.op     = OP_TAB_RUN;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/text_line_layout_runs.sv =====
// Top level of the text line layout block: draw runs from a character stream.
// Depends on tlr_pkg, tlr_ctrl, tlr_datapath (and tlr_rem below it).
//
//  channel | dir | handshake          | contents
//  s_*     | in  | s_tvalid/s_tready  | one item: command, start point, char
//  m_*     | out | m_tvalid/m_tready  | one draw run, up to three per item
//  cfg_*   | in  | cfg_valid/cfg_ready| register index and write data
//
// Begin, end and plain characters are latched on acceptance and then executed.
// A tab flushes the open run, waits for the remainder unit that finds the tab
// stop 4 bits a cycle, then places the stop, wrapping if needed, and emits the tab run.
// A new word is taken while a finished run still waits in the output
// register; a stalled output holds the sequencer before its next run.
// Reset is synchronous and restores the register defaults and zero state.
module text_line_layout_runs #(
  parameter int COORD_BITS = 16,
  parameter int INDEX_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // start_x, start_y, char_code, char_width, zero pad
  input  logic [tlr_pkg::S_TDATA_BITS-1:0]   s_tdata,
  // command
  input  logic [1:0]                         s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // run_start_x, run_y, run_end_x, first_index, run_length, zero pad
  output logic [tlr_pkg::M_TDATA_BITS-1:0]   m_tdata,
  // complete
  output logic [0:0]                         m_tuser,
  output logic                               m_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tlr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [tlr_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import tlr_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  tlr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .status   (status)
  );

  tlr_datapath #(
    .COORD_BITS (COORD_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// ===== verif/tb_text_line_layout_runs.sv =====
// Self-checking bench for text_line_layout_runs: drives item words and register writes,
// predicts every draw run in-bench and compares each run word field by field.
// Depends on tlr_pkg and the text_line_layout_runs RTL only.
module tb_text_line_layout_runs;
  import tlr_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 16;     // covers the tab path with margin
  localparam int QUIET_LIMIT = 5000;
  localparam int ITEMS_PER_PHASE = 70;
  localparam int MAX_PRINTED = 40;

  typedef struct {
    logic [14:0] x0;
    logic [14:0] y;
    logic [14:0] x1;
    logic [15:0] first;
    logic [15:0] len;
    logic        done;
    logic        last;
  } draw_run_t;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [S_TDATA_BITS-1:0]   s_tdata = '0;
  logic [1:0]                s_tuser = '0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [M_TDATA_BITS-1:0]   m_tdata;
  logic [0:0]                m_tuser;
  logic                      m_tlast;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  text_line_layout_runs u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // frame registers as the block should hold them
  logic [14:0] fr_left   = RST_FRAME_LEFT;
  logic [14:0] fr_right  = RST_FRAME_RIGHT;
  logic [14:0] fr_bottom = RST_FRAME_BOTTOM;
  logic [9:0]  fr_tab    = RST_TAB_WIDTH;
  logic [7:0]  fr_lh     = RST_LINE_HEIGHT;

  // layout state
  logic [15:0] lay_pen = '0;
  logic [15:0] lay_run_x = '0;
  logic [15:0] lay_y = '0;
  logic [15:0] lay_count = '0;
  logic [15:0] lay_first = '0;
  logic [15:0] lay_index = '0;
  logic        lay_halted = 1'b0;

  draw_run_t expected_runs[$];
  int mismatches = 0;
  int items_done = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int quiet_cycles = 0;

  // ---------------- layout predictor ----------------

  task automatic emit_run(input logic [15:0] x0, input logic [15:0] x1,
                          input logic [15:0] first, input logic [15:0] len,
                          input logic done);
    draw_run_t r;
    r.x0 = x0[14:0];
    r.y = lay_y[14:0];
    r.x1 = x1[14:0];
    r.first = first;
    r.len = len;
    r.done = done;
    r.last = 1'b0;
    expected_runs.push_back(r);
  endtask

  task automatic start_line();
    lay_count = '0;
    lay_run_x = {1'b0, fr_left};
    lay_y = lay_y + fr_lh;
    if (lay_y >= fr_bottom) lay_halted = 1'b1;
    lay_pen = {1'b0, fr_left};
    lay_first = lay_index;
  endtask

  // truncating division: an offset behind the left edge still lands right of the pen
  function automatic logic [15:0] tab_stop(input logic [15:0] x);
    longint tw, off, s;
    tw = (fr_tab == 0) ? 1 : longint'(fr_tab);
    off = longint'(x) - longint'(fr_left);
    s = off - (off % tw) + tw + longint'(fr_left);
    return s[15:0];
  endfunction

  task automatic place_char(input logic [7:0] code, input logic [7:0] width);
    logic [15:0] target;
    if (code == CHR_NEWLINE) begin
      lay_index = lay_index + 16'd1;
      emit_run(lay_run_x, {1'b0, fr_right}, lay_first, lay_count + 16'd1, 1'b0);
      start_line();
      return;
    end
    if (code == CHR_TAB) begin
      if (lay_count != 0) begin
        emit_run(lay_run_x, lay_pen, lay_first, lay_count, 1'b0);
        lay_run_x = lay_pen;
        lay_count = '0;
        lay_first = lay_index;
      end
      target = tab_stop(lay_pen);
      if (target > fr_right) begin
        emit_run(lay_run_x, {1'b0, fr_right}, lay_first, lay_count, 1'b0);
        start_line();
        if (lay_halted) return;
        target = tab_stop(lay_pen);   // no second wrap even if still too far
      end
      lay_pen = target;
      emit_run(lay_run_x, lay_pen, lay_index, 16'd1, 1'b0);
      lay_index = lay_index + 16'd1;
      lay_run_x = lay_pen;
      lay_count = '0;
      lay_first = lay_index;
      return;
    end
    if (code >= CHR_PRINT_LO && code <= CHR_PRINT_HI) begin
      target = lay_pen + width;
      if (target > fr_right) begin
        emit_run(lay_run_x, {1'b0, fr_right}, lay_first, lay_count, 1'b0);
        start_line();
        if (lay_halted) return;
        target = lay_pen + width;
      end
      lay_pen = target;
    end
    lay_index = lay_index + 16'd1;
    lay_count = lay_count + 16'd1;
  endtask

  task automatic predict_item(input logic [1:0] cmd, input logic [14:0] sx,
                              input logic [14:0] sy, input logic [7:0] code,
                              input logic [7:0] width);
    int before_n;
    before_n = expected_runs.size();
    case (cmd)
      CMD_BEGIN: begin
        lay_pen = {1'b0, sx};
        lay_run_x = {1'b0, sx};
        lay_y = {1'b0, sy};
        lay_count = '0;
        lay_first = '0;
        lay_index = '0;
        lay_halted = 1'b0;
      end
      CMD_CHAR: if (!lay_halted) place_char(code, width);
      CMD_END: begin
        if (!lay_halted && lay_y < fr_bottom)
          emit_run(lay_run_x, lay_pen, lay_first, lay_count, 1'b1);
        lay_halted = 1'b1;
      end
      default: ;
    endcase
    if (expected_runs.size() > before_n) expected_runs[$].last = 1'b1;
  endtask

  // ---------------- drivers ----------------

  task automatic send_item(input logic [1:0] cmd, input logic [14:0] sx,
                           input logic [14:0] sy, input logic [7:0] code,
                           input logic [7:0] width);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {2'b00, width, code, sy, sx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_done++;
    predict_item(cmd, sx, sy, code, width);
  endtask

  task automatic send_char(input logic [7:0] code, input logic [7:0] width);
    send_item(CMD_CHAR, 15'($urandom), 15'($urandom), code, width);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [14:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_FRAME_LEFT:   fr_left = data;
      REG_FRAME_RIGHT:  fr_right = data;
      REG_FRAME_BOTTOM: fr_bottom = data;
      REG_TAB_WIDTH:    fr_tab = data[9:0];
      REG_LINE_HEIGHT:  fr_lh = data[7:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame(input int left, input int right, input int bottom,
                           input int tab, input int lh);
    write_reg(REG_FRAME_LEFT, left[14:0]);
    write_reg(REG_FRAME_RIGHT, right[14:0]);
    write_reg(REG_FRAME_BOTTOM, bottom[14:0]);
    write_reg(REG_TAB_WIDTH, {5'b0, tab[9:0]});
    write_reg(REG_LINE_HEIGHT, {7'b0, lh[7:0]});
  endtask

  // wait for every predicted run, then let any no-result item finish
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_runs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(input int tx, input int rx);
    tx_idle_pct = tx;
    rx_idle_pct = rx;
  endtask

  // ---------------- run word checking ----------------

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  always @(posedge clk) begin : check_runs
    draw_run_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_runs.size() == 0) begin
        report_mismatch($sformatf("run word with nothing pending: %h", m_tdata));
      end else begin
        want = expected_runs.pop_front();
        compare_field("run_start_x", {1'b0, m_tdata[14:0]}, {1'b0, want.x0});
        compare_field("run_y", {1'b0, m_tdata[29:15]}, {1'b0, want.y});
        compare_field("run_end_x", {1'b0, m_tdata[44:30]}, {1'b0, want.x1});
        compare_field("first_index", m_tdata[60:45], want.first);
        compare_field("run_length", m_tdata[76:61], want.len);
        compare_field("complete", {15'b0, m_tuser[0]}, {15'b0, want.done});
        compare_field("tlast", {15'b0, m_tlast}, {15'b0, want.last});
      end
    end
  end

  always @(posedge clk) m_tready <= ($urandom_range(99) >= rx_idle_pct);

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", QUIET_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------- tests ----------------

  // characters laid out from the reset state, and an unknown command
  task automatic test_before_begin();
    send_char(8'd65, 8'd8);
    send_item(CMD_UNUSED, 15'h7fff, 15'h7fff, 8'hff, 8'hff);
    send_char(CHR_NEWLINE, 8'd0);
  endtask

  // default frame: wrap, tab flush, newline, zero-width codes, end, halted input
  task automatic test_wrap_and_tabs();
    send_item(CMD_BEGIN, 15'd1000, 15'd0, 8'd0, 8'd0);
    send_char(8'd87, 8'd255);
    send_char(CHR_TAB, 8'd0);
    send_char(CHR_NEWLINE, 8'd0);
    send_char(8'd0, 8'd255);
    send_char(8'd255, 8'd0);
    send_char(CHR_PRINT_HI, 8'd0);
    send_char(CHR_PRINT_LO, 8'd1);
    send_char(CHR_TAB, 8'd0);
    send_item(CMD_END, 15'd0, 15'd0, 8'd0, 8'd0);
    send_char(8'd65, 8'd8);
    send_item(CMD_END, 15'd0, 15'd0, 8'd0, 8'd0);
  endtask

  // items wider than the frame, tab behind the left edge, bottom stop, max start point
  task automatic test_narrow_frame();
    settle();
    set_frame(500, 600, 600, 1023, 255);
    send_item(CMD_BEGIN, 15'd100, 15'd0, 8'd0, 8'd0);
    send_char(CHR_TAB, 8'd0);
    send_char(8'd77, 8'd200);
    send_char(CHR_NEWLINE, 8'd0);
    send_item(CMD_END, 15'd0, 15'd0, 8'd0, 8'd0);
    send_item(CMD_BEGIN, 15'h7fff, 15'h7fff, 8'd0, 8'd0);
    send_item(CMD_END, 15'd0, 15'd0, 8'd0, 8'd0);
  endtask

  // zero tab width acts as one; unused register index has no effect
  task automatic test_zero_tab();
    settle();
    set_frame(0, 32767, 32767, 0, 1);
    write_reg(REG_UNUSED, 15'h5a5a);
    send_item(CMD_BEGIN, 15'd5, 15'd5, 8'd0, 8'd0);
    send_char(CHR_TAB, 8'd0);
    send_item(CMD_END, 15'd0, 15'd0, 8'd0, 8'd0);
  endtask

  task automatic random_char();
    int r;
    logic [7:0] w;
    r = $urandom_range(99);
    w = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 40));
    if (r < 65) send_char(8'($urandom_range(CHR_PRINT_LO, CHR_PRINT_HI)), w);
    else if (r < 78) send_char(CHR_NEWLINE, w);
    else if (r < 90) send_char(CHR_TAB, w);
    else send_char(8'($urandom), 8'($urandom));
  endtask

  // mostly begin / characters / end paragraphs, some stray words
  task automatic random_text_block();
    int lo, hi, n;
    logic [14:0] x, y;
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(2))
        0: send_item(CMD_UNUSED, 15'($urandom), 15'($urandom), 8'($urandom), 8'($urandom));
        1: send_item(CMD_END, 15'($urandom), 15'($urandom), 8'($urandom), 8'($urandom));
        default: random_char();
      endcase
    end else begin
      lo = fr_left;
      hi = (fr_right < fr_left) ? fr_left : fr_right;
      x = ($urandom_range(9) == 0) ? 15'($urandom) : 15'($urandom_range(lo, hi));
      y = ($urandom_range(9) == 0) ? 15'($urandom) : 15'($urandom_range(0, fr_bottom));
      send_item(CMD_BEGIN, x, y, 8'($urandom), 8'($urandom));
      n = $urandom_range(3, 30);
      repeat (n) random_char();
      if ($urandom_range(7) != 0)
        send_item(CMD_END, 15'($urandom), 15'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_random_text();
    int left;
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        1: set_frame(32767, 32767, 32767, 1023, 255);
        3: set_frame(0, 0, 0, 0, 0);
        default: begin
          left = $urandom_range(0, 3000);
          set_frame(left, left + $urandom_range(60, 1200), $urandom_range(100, 3000),
                    ($urandom_range(4) == 0) ? 1023 : $urandom_range(1, 150),
                    $urandom_range(2, 40));
        end
      endcase
      if (ph < 2) set_idling(29, 46);
      else if (ph < 4) set_idling(46, 29);
      else set_idling(0, 0);
      items_done = 0;
      while (items_done < ITEMS_PER_PHASE) random_text_block();
    end
  endtask

  initial begin
    set_idling(29, 46);
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_before_begin();
    test_wrap_and_tabs();
    test_narrow_frame();
    test_zero_tab();
    test_random_text();
    settle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
